>>> hdl/bcf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcf_pkg
// Shared types and constants for the bencode command framer: parser states,
// result status codes, register map and the characters the parser looks for.
// ----------------------------------------------------------------------------
package bcf_pkg;

  // default width of the internal length counters
  localparam int DEFAULT_LENGTH_BITS = 14;

  // width of the length fields on the result channel
  localparam int LEN_OUT_BITS = 14;

  // register map
  localparam int APB_ADDR_BITS = 3;
  localparam int APB_DATA_BITS = 32;
  localparam int CFG_LEN_BITS  = 14;
  localparam logic REG_MAX_MESSAGE_LENGTH = 1'b0;
  localparam logic [CFG_LEN_BITS-1:0] MAX_LEN_RESET = 14'd8192;

  // result status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_FORMAT   = 2'd1;
  localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

  // characters of the framing
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_D     = 8'h64;
  localparam logic [7:0] CHAR_E     = 8'h65;
  localparam logic [7:0] CHAR_L     = 8'h6c;
  localparam logic [7:0] CHAR_COLON = 8'h3a;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_ONE   = 8'h31;
  localparam logic [7:0] CHAR_SEVEN = 8'h37;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // number of characters in the call-id key text
  localparam logic [2:0] CALLID_CHARS = 3'd7;

  // parser states
  typedef enum logic [3:0] {
    ST_HUNT   = 4'd0,
    ST_KFIRST = 4'd1,
    ST_KLEN   = 4'd2,
    ST_KBODY  = 4'd3,
    ST_VSTART = 4'd4,
    ST_VLEN   = 4'd5,
    ST_VBODY  = 4'd6,
    ST_LITEM  = 4'd7,
    ST_LLEN   = 4'd8,
    ST_LBODY  = 4'd9,
    ST_AFTER  = 4'd10
  } parse_state_t;

  // one finished command as handed from the parser to the output stage
  typedef struct packed {
    logic [1:0]              status;
    logic [LEN_OUT_BITS-1:0] message_length;
    logic [LEN_OUT_BITS-1:0] cookie_length;
    logic                    call_id_found;
    logic [LEN_OUT_BITS-1:0] call_id_offset;
    logic [LEN_OUT_BITS-1:0] call_id_length;
  } result_t;

  // text of the call-id key, one character per index
  function automatic logic [7:0] callid_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0: c = 8'h63;   // c
      3'd1: c = 8'h61;   // a
      3'd2: c = 8'h6c;   // l
      3'd3: c = 8'h6c;   // l
      3'd4: c = 8'h2d;   // -
      3'd5: c = 8'h69;   // i
      3'd6: c = 8'h64;   // d
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

>>> hdl/bencode_command_framer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bencode_command_framer
// Frames bencoded control commands out of a byte stream and reports each
// command's length, cookie length and call-id value position.
// ----------------------------------------------------------------------------
// Usage:
//   Bytes enter on the s_ stream, one per transaction, with tuser[0] set to
//   drop any partial command (connection reopened). Each finished, malformed
//   or over-long command produces one transaction on the m_ stream; bytes
//   inside a command produce none. The length limit is written over APB
//   at address 0 while the stream is idle.
//   Throughput is one byte per cycle while no result is stalled: a byte is
//   held in an input register, and the parser state and the result register
//   are updated from it when the result slot is free, so m_tvalid rises from
//   the result register once the byte ending the command has been parsed.
//   When the receiver stalls with a result pending, the input register fills
//   and s_tready drops until the result is taken; no byte is lost.
//   Reset clears the parser to cookie hunting, empties both registers and
//   sets the limit to 8192 bytes.
// ----------------------------------------------------------------------------
module bencode_command_framer import bcf_pkg::*; #(
  parameter int LENGTH_BITS = DEFAULT_LENGTH_BITS
) (
  input  wire                      clk,
  input  wire                      rst,
  // byte stream in
  input  wire                      s_tvalid,
  output logic                     s_tready,
  input  wire [7:0]                s_tdata,   // [7:0] data_byte
  input  wire [0:0]                s_tuser,   // [0] stream_restart
  // result stream out
  output logic                     m_tvalid,
  input  wire                      m_tready,
  output logic [63:0]              m_tdata,   // [13:0] message_length,
                                              // [27:14] cookie_length,
                                              // [28] call_id_found,
                                              // [42:29] call_id_offset,
                                              // [56:43] call_id_length,
                                              // [63:57] zero
  output logic [1:0]               m_tuser,   // [1:0] status
  // configuration
  input  wire                      psel,
  input  wire                      penable,
  input  wire                      pwrite,
  input  wire [APB_ADDR_BITS-1:0]  paddr,
  input  wire [APB_DATA_BITS-1:0]  pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready
);

  logic [CFG_LEN_BITS-1:0] max_message_length;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_restart;
  logic       out_free;
  logic       advance;
  logic       res_valid;
  result_t    res;

  // register file
  bcf_cfg_regs u_cfg (
    .clk                (clk),
    .rst                (rst),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .max_message_length (max_message_length)
  );

  // handshake: the input register drains whenever the result slot is free
  assign out_free = !m_tvalid || m_tready;
  assign advance  = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte    <= s_tdata;
      in_restart <= s_tuser[0];
    end
  end

  // parser
  bcf_parse_core #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_core (
    .clk                (clk),
    .rst                (rst),
    .step               (advance),
    .data_byte          (in_byte),
    .stream_restart     (in_restart),
    .max_message_length (max_message_length),
    .res_valid          (res_valid),
    .res                (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      m_tuser <= res.status;
      m_tdata <= {7'd0, res.call_id_length, res.call_id_offset, res.call_id_found,
                  res.cookie_length, res.message_length};
    end
  end

`ifndef SYNTHESIS
  // the parser never steps while a result is stuck in the output register
  a_no_step_on_stall: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !advance)
    else $error("parser stepped while result stalled");

  // input side only backs up when a byte is waiting
  a_ready_low_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (in_valid && m_tvalid && !m_tready))
    else $error("s_tready low without a full pipeline");

  // reset empties both registers
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!m_tvalid && !in_valid))
    else $error("pipeline not empty after reset");

  // only defined status codes leave the block
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tuser == STATUS_OK) || (m_tuser == STATUS_FORMAT)
                  || (m_tuser == STATUS_TOO_LONG)))
    else $error("undefined result status");
`endif

endmodule
`default_nettype wire

>>> hdl/bcf_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcf_cfg_regs
// APB register file holding the message length limit.
// ----------------------------------------------------------------------------
module bcf_cfg_regs import bcf_pkg::*; (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      psel,
  input  wire                      penable,
  input  wire                      pwrite,
  input  wire [APB_ADDR_BITS-1:0]  paddr,
  input  wire [APB_DATA_BITS-1:0]  pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready,
  output logic [CFG_LEN_BITS-1:0]  max_message_length
);

  logic wr_en;

  assign pready = 1'b1;

  // write at the access phase, registers sit on word addresses
  assign wr_en = psel && penable && pwrite
                 && (paddr[APB_ADDR_BITS-1] == REG_MAX_MESSAGE_LENGTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_message_length <= MAX_LEN_RESET;
    end else if (wr_en) begin
      max_message_length <= pwdata[CFG_LEN_BITS-1:0];
    end
  end

  // read back
  always_comb begin
    if (paddr[APB_ADDR_BITS-1] == REG_MAX_MESSAGE_LENGTH) begin
      prdata = APB_DATA_BITS'(max_message_length);
    end else begin
      prdata = '0;
    end
  end

endmodule
`default_nettype wire

>>> hdl/bcf_parse_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcf_parse_core
// Per-byte parser state machine: tracks cookie, keys, values and lists,
// counts bytes against the limit and produces a result when a command ends.
// ----------------------------------------------------------------------------
module bcf_parse_core import bcf_pkg::*; #(
  parameter int LENGTH_BITS = DEFAULT_LENGTH_BITS
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    step,
  input  wire [7:0]              data_byte,
  input  wire                    stream_restart,
  input  wire [CFG_LEN_BITS-1:0] max_message_length,
  output logic                   res_valid,
  output result_t                res
);

  localparam int CmpBits  = ((LENGTH_BITS > CFG_LEN_BITS) ? LENGTH_BITS : CFG_LEN_BITS) + 1;
  localparam int ProdBits = LENGTH_BITS + 4;
  localparam logic [LENGTH_BITS-1:0] LenMask = '1;

  // state registers
  parse_state_t           parse_state;
  logic                   prev_was_space;
  logic [LENGTH_BITS-1:0] length_accum;
  logic [LENGTH_BITS-1:0] bytes_remaining;
  logic [LENGTH_BITS-1:0] byte_count;
  logic [LENGTH_BITS-1:0] cookie_len_reg;
  logic [2:0]             key_match_index;
  logic                   key_is_callid;
  logic                   callid_seen;
  logic [LENGTH_BITS-1:0] callid_start;
  logic [LENGTH_BITS-1:0] callid_len;

  // next values
  parse_state_t           parse_state_next;
  logic                   prev_was_space_next;
  logic [LENGTH_BITS-1:0] length_accum_next;
  logic [LENGTH_BITS-1:0] bytes_remaining_next;
  logic [LENGTH_BITS-1:0] cookie_len_reg_next;
  logic [2:0]             key_match_index_next;
  logic                   key_is_callid_next;
  logic                   callid_seen_next;
  logic [LENGTH_BITS-1:0] callid_start_next;
  logic [LENGTH_BITS-1:0] callid_len_next;

  // view of the state after an optional restart
  parse_state_t           cur_state;
  logic                   cur_pws;
  logic [LENGTH_BITS-1:0] cur_acc;
  logic [LENGTH_BITS-1:0] cur_rem;
  logic [LENGTH_BITS-1:0] cur_bc;
  logic [LENGTH_BITS-1:0] cur_ckl;
  logic [2:0]             cur_kmi;
  logic                   cur_kic;
  logic                   cur_cs;
  logic [LENGTH_BITS-1:0] cur_cst;
  logic [LENGTH_BITS-1:0] cur_cln;

  logic [LENGTH_BITS:0]   cnt_wide;
  logic [LENGTH_BITS-1:0] cnt;
  logic [CmpBits-1:0]     cnt_cmp;
  logic [CmpBits-1:0]     limit_cmp;
  logic                   too_long;
  logic                   is_digit;
  logic                   is_nonzero_digit;
  logic [LENGTH_BITS-1:0] digit_val;
  logic [ProdBits-1:0]    acc_prod;
  logic [LENGTH_BITS-1:0] acc_sat;
  logic [LENGTH_BITS-1:0] rem_dec;
  logic                   rem_last;
  logic                   len_bad;
  logic                   clear_all;
  logic                   emit;
  logic [1:0]             emit_status;
  logic [LENGTH_BITS-1:0] emit_len;

  // a restart drops the partial command before this byte is looked at
  always_comb begin
    if (stream_restart) begin
      cur_state = ST_HUNT;
      cur_pws   = 1'b0;
      cur_acc   = '0;
      cur_rem   = '0;
      cur_bc    = '0;
      cur_ckl   = '0;
      cur_kmi   = '0;
      cur_kic   = 1'b0;
      cur_cs    = 1'b0;
      cur_cst   = '0;
      cur_cln   = '0;
    end else begin
      cur_state = parse_state;
      cur_pws   = prev_was_space;
      cur_acc   = length_accum;
      cur_rem   = bytes_remaining;
      cur_bc    = byte_count;
      cur_ckl   = cookie_len_reg;
      cur_kmi   = key_match_index;
      cur_kic   = key_is_callid;
      cur_cs    = callid_seen;
      cur_cst   = callid_start;
      cur_cln   = callid_len;
    end
  end

  // byte count against the limit, clamped to counter capacity
  assign cnt_wide  = {1'b0, cur_bc} + (LENGTH_BITS+1)'(1);
  assign cnt       = cnt_wide[LENGTH_BITS-1:0];
  assign cnt_cmp   = CmpBits'(cnt_wide);
  assign limit_cmp = (CmpBits'(max_message_length) > CmpBits'(LenMask))
                     ? CmpBits'(LenMask) : CmpBits'(max_message_length);
  assign too_long  = cnt_cmp > limit_cmp;

  // character classes and decimal length accumulation
  assign is_digit         = (data_byte >= CHAR_ZERO) && (data_byte <= CHAR_NINE);
  assign is_nonzero_digit = (data_byte >= CHAR_ONE) && (data_byte <= CHAR_NINE);
  assign digit_val        = LENGTH_BITS'(data_byte[3:0]);
  assign acc_prod = ProdBits'(cur_acc) * ProdBits'(10) + ProdBits'(data_byte[3:0]);
  assign acc_sat  = (acc_prod > ProdBits'(LenMask)) ? LenMask : acc_prod[LENGTH_BITS-1:0];
  assign rem_dec  = cur_rem - LENGTH_BITS'(1);
  assign rem_last = (cur_rem == LENGTH_BITS'(1));
  assign len_bad  = (data_byte != CHAR_COLON) || (cur_acc == '0);

  // next state
  always_comb begin
    parse_state_next = cur_state;
    if (too_long) begin
      parse_state_next = ST_HUNT;
    end else begin
      unique case (cur_state)
        ST_HUNT: begin
          if (cur_pws && (data_byte == CHAR_D)) parse_state_next = ST_KFIRST;
        end
        ST_AFTER, ST_KFIRST: begin
          if ((cur_state == ST_AFTER) && (data_byte == CHAR_E)) parse_state_next = ST_HUNT;
          else if (is_digit) parse_state_next = ST_KLEN;
          else parse_state_next = ST_HUNT;
        end
        ST_KLEN: begin
          if (is_digit) parse_state_next = ST_KLEN;
          else if (len_bad) parse_state_next = ST_HUNT;
          else parse_state_next = ST_KBODY;
        end
        ST_KBODY: begin
          if (rem_last) parse_state_next = ST_VSTART;
        end
        ST_VSTART: begin
          if (is_digit) parse_state_next = ST_VLEN;
          else if (data_byte == CHAR_L) parse_state_next = ST_LITEM;
          else parse_state_next = ST_HUNT;
        end
        ST_VLEN: begin
          if (is_digit) parse_state_next = ST_VLEN;
          else if (len_bad) parse_state_next = ST_HUNT;
          else parse_state_next = ST_VBODY;
        end
        ST_VBODY: begin
          if (rem_last) parse_state_next = ST_AFTER;
        end
        ST_LBODY: begin
          if (rem_last) parse_state_next = ST_LITEM;
        end
        ST_LITEM: begin
          if (data_byte == CHAR_E) parse_state_next = ST_AFTER;
          else if (is_nonzero_digit) parse_state_next = ST_LLEN;
          else parse_state_next = ST_HUNT;
        end
        ST_LLEN: begin
          if (is_digit) parse_state_next = ST_LLEN;
          else if (data_byte != CHAR_COLON) parse_state_next = ST_HUNT;
          else parse_state_next = ST_LBODY;
        end
        default: parse_state_next = ST_HUNT;
      endcase
    end
  end

  // datapath updates and result generation
  always_comb begin
    prev_was_space_next  = cur_pws;
    length_accum_next    = cur_acc;
    bytes_remaining_next = cur_rem;
    cookie_len_reg_next  = cur_ckl;
    key_match_index_next = cur_kmi;
    key_is_callid_next   = cur_kic;
    callid_seen_next     = cur_cs;
    callid_start_next    = cur_cst;
    callid_len_next      = cur_cln;
    clear_all            = 1'b0;
    emit                 = 1'b0;
    emit_status          = STATUS_OK;
    emit_len             = cnt;
    if (too_long) begin
      emit        = 1'b1;
      emit_status = STATUS_TOO_LONG;
      emit_len    = cur_bc;
    end else begin
      unique case (cur_state)
        ST_HUNT: begin
          if (cur_pws && (data_byte == CHAR_D)) begin
            cookie_len_reg_next = cur_bc - LENGTH_BITS'(1);
          end
          prev_was_space_next = (data_byte == CHAR_SPACE);
        end
        ST_AFTER, ST_KFIRST: begin
          if ((cur_state == ST_AFTER) && (data_byte == CHAR_E)) begin
            emit = 1'b1;
          end else if (!is_digit) begin
            emit        = 1'b1;
            emit_status = STATUS_FORMAT;
          end else begin
            length_accum_next    = digit_val;
            key_is_callid_next   = (data_byte == CHAR_SEVEN);
            key_match_index_next = '0;
          end
        end
        ST_KLEN: begin
          if (is_digit) begin
            length_accum_next  = acc_sat;
            key_is_callid_next = 1'b0;
          end else if (len_bad) begin
            emit        = 1'b1;
            emit_status = STATUS_FORMAT;
          end else begin
            bytes_remaining_next = cur_acc;
          end
        end
        ST_KBODY: begin
          // compare the key text against call-id one byte at a time
          if (cur_kic) begin
            if ((cur_kmi < CALLID_CHARS) && (data_byte == callid_char(cur_kmi))) begin
              key_match_index_next = cur_kmi + 3'd1;
            end else begin
              key_is_callid_next = 1'b0;
            end
          end
          bytes_remaining_next = rem_dec;
        end
        ST_VSTART: begin
          if (is_digit) begin
            length_accum_next = digit_val;
          end else if (data_byte == CHAR_L) begin
            key_is_callid_next = 1'b0;
          end else begin
            emit        = 1'b1;
            emit_status = STATUS_FORMAT;
          end
        end
        ST_VLEN: begin
          if (is_digit) begin
            length_accum_next = acc_sat;
          end else if (len_bad) begin
            emit        = 1'b1;
            emit_status = STATUS_FORMAT;
          end else begin
            bytes_remaining_next = cur_acc;
            // value string right after the call-id key
            if (cur_kic) begin
              callid_seen_next  = 1'b1;
              callid_start_next = cnt;
              callid_len_next   = cur_acc;
            end
            key_is_callid_next = 1'b0;
          end
        end
        ST_VBODY, ST_LBODY: begin
          bytes_remaining_next = rem_dec;
        end
        ST_LITEM: begin
          if (data_byte == CHAR_E) begin
            emit = 1'b0;
          end else if (is_nonzero_digit) begin
            length_accum_next = digit_val;
          end else begin
            emit        = 1'b1;
            emit_status = STATUS_FORMAT;
          end
        end
        ST_LLEN: begin
          if (is_digit) begin
            length_accum_next = acc_sat;
          end else if (data_byte != CHAR_COLON) begin
            emit        = 1'b1;
            emit_status = STATUS_FORMAT;
          end else begin
            bytes_remaining_next = cur_acc;
          end
        end
        default: clear_all = 1'b1;
      endcase
    end
  end

  // result fields from the state as it stood for this byte
  always_comb begin
    res_valid          = emit;
    res.status         = emit_status;
    res.message_length = LEN_OUT_BITS'(emit_len);
    res.cookie_length  = LEN_OUT_BITS'(cur_ckl);
    res.call_id_found  = cur_cs;
    res.call_id_offset = cur_cs ? LEN_OUT_BITS'(cur_cst) : '0;
    res.call_id_length = cur_cs ? LEN_OUT_BITS'(cur_cln) : '0;
  end

  // state update, a finished command clears everything
  always_ff @(posedge clk) begin
    if (rst || (step && (emit || clear_all))) begin
      parse_state     <= ST_HUNT;
      prev_was_space  <= 1'b0;
      length_accum    <= '0;
      bytes_remaining <= '0;
      byte_count      <= '0;
      cookie_len_reg  <= '0;
      key_match_index <= '0;
      key_is_callid   <= 1'b0;
      callid_seen     <= 1'b0;
      callid_start    <= '0;
      callid_len      <= '0;
    end else if (step) begin
      parse_state     <= parse_state_next;
      prev_was_space  <= prev_was_space_next;
      length_accum    <= length_accum_next;
      bytes_remaining <= bytes_remaining_next;
      byte_count      <= cnt;
      cookie_len_reg  <= cookie_len_reg_next;
      key_match_index <= key_match_index_next;
      key_is_callid   <= key_is_callid_next;
      callid_seen     <= callid_seen_next;
      callid_start    <= callid_start_next;
      callid_len      <= callid_len_next;
    end
  end

endmodule
`default_nettype wire

>>> bench/command_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command_result_checker
// Watches the byte stream, the result stream and the register writes of the
// bencode command framer. Every accepted byte runs through a local command
// parser. Every result is compared field by field with the oldest predicted
// command.
// ----------------------------------------------------------------------------
module command_result_checker import bcf_pkg::*; (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     s_tvalid,
  input  wire                     s_tready,
  input  wire [7:0]               s_tdata,   // [7:0] data_byte
  input  wire [0:0]               s_tuser,   // [0] stream_restart
  input  wire                     m_tvalid,
  input  wire                     m_tready,
  input  wire [63:0]              m_tdata,   // [13:0] message_length,
                                             // [27:14] cookie_length,
                                             // [28] call_id_found,
                                             // [42:29] call_id_offset,
                                             // [56:43] call_id_length
  input  wire [1:0]               m_tuser,   // [1:0] status
  input  wire                     psel,
  input  wire                     penable,
  input  wire                     pwrite,
  input  wire [APB_ADDR_BITS-1:0] paddr,
  input  wire [APB_DATA_BITS-1:0] pwdata,
  input  wire                     pready,
  output int                      fail_count,
  output int                      pending_results,
  output int                      checked_results
);

  localparam int LEN_SAT = (1 << DEFAULT_LENGTH_BITS) - 1;
  localparam logic [55:0] CALLID_KEY = "call-id";

  // local parser state
  parse_state_t              pstate;
  bit                        after_space;
  int                        len_acc;
  int                        remain;
  int                        msg_bytes;
  int                        cookie_bytes;
  int                        key_pos;
  bit                        maybe_callid;
  bit                        callid_valid;
  int                        callid_off;
  int                        callid_size;
  logic [CFG_LEN_BITS-1:0]   len_limit;

  // predicted results, oldest first
  result_t expected_commands[$];

  function automatic logic [7:0] callid_at(input int idx);
    return CALLID_KEY[55 - 8 * idx -: 8];
  endfunction

  function automatic bit is_digit(input logic [7:0] b);
    return b >= CHAR_ZERO && b <= CHAR_NINE;
  endfunction

  // decimal length accumulation, saturating at the counter capacity
  function automatic int add_digit(input int acc, input logic [7:0] b);
    int v;
    v = acc * 10 + (int'(b) - int'(CHAR_ZERO));
    return (v > LEN_SAT) ? LEN_SAT : v;
  endfunction

  task clear_command();
    pstate       = ST_HUNT;
    after_space  = 1'b0;
    len_acc      = 0;
    remain       = 0;
    msg_bytes    = 0;
    cookie_bytes = 0;
    key_pos      = 0;
    maybe_callid = 1'b0;
    callid_valid = 1'b0;
    callid_off   = 0;
    callid_size  = 0;
  endtask

  task close_command(input logic [1:0] status, input int len);
    result_t r;
    r.status         = status;
    r.message_length = len[LEN_OUT_BITS-1:0];
    r.cookie_length  = cookie_bytes[LEN_OUT_BITS-1:0];
    r.call_id_found  = callid_valid;
    r.call_id_offset = callid_valid ? callid_off[LEN_OUT_BITS-1:0] : '0;
    r.call_id_length = callid_valid ? callid_size[LEN_OUT_BITS-1:0] : '0;
    expected_commands.insert(expected_commands.size(), r);
    clear_command();
  endtask

  // one byte through the command parser
  task parse_command_byte(input logic [7:0] b, input logic restart);
    int cnt;
    if (restart) clear_command();
    cnt = msg_bytes + 1;
    if (cnt > int'(len_limit)) begin
      // byte dropped, command reported with what was kept
      close_command(STATUS_TOO_LONG, msg_bytes);
    end else begin
      msg_bytes = cnt;
      case (pstate)
        ST_HUNT: begin
          if (after_space && b == CHAR_D) begin
            cookie_bytes = cnt - 2;
            pstate = ST_KFIRST;
          end
          after_space = (b == CHAR_SPACE);
        end
        ST_AFTER, ST_KFIRST: begin
          if (pstate == ST_AFTER && b == CHAR_E) begin
            close_command(STATUS_OK, cnt);
          end else if (!is_digit(b)) begin
            close_command(STATUS_FORMAT, cnt);
          end else begin
            len_acc = int'(b) - int'(CHAR_ZERO);
            maybe_callid = (b == CHAR_SEVEN);
            key_pos = 0;
            pstate = ST_KLEN;
          end
        end
        ST_KLEN: begin
          if (is_digit(b)) begin
            len_acc = add_digit(len_acc, b);
            maybe_callid = 1'b0;
          end else if (b != CHAR_COLON || len_acc == 0) begin
            close_command(STATUS_FORMAT, cnt);
          end else begin
            remain = len_acc;
            pstate = ST_KBODY;
          end
        end
        ST_KBODY: begin
          if (maybe_callid) begin
            if (key_pos < int'(CALLID_CHARS) && b == callid_at(key_pos)) key_pos++;
            else maybe_callid = 1'b0;
          end
          remain--;
          if (remain == 0) pstate = ST_VSTART;
        end
        ST_VSTART: begin
          if (is_digit(b)) begin
            len_acc = int'(b) - int'(CHAR_ZERO);
            pstate = ST_VLEN;
          end else if (b == CHAR_L) begin
            maybe_callid = 1'b0;
            pstate = ST_LITEM;
          end else begin
            close_command(STATUS_FORMAT, cnt);
          end
        end
        ST_VLEN: begin
          if (is_digit(b)) begin
            len_acc = add_digit(len_acc, b);
          end else if (b != CHAR_COLON || len_acc == 0) begin
            close_command(STATUS_FORMAT, cnt);
          end else begin
            remain = len_acc;
            // string value right after the call-id key
            if (maybe_callid) begin
              callid_valid = 1'b1;
              callid_off = cnt;
              callid_size = len_acc;
            end
            maybe_callid = 1'b0;
            pstate = ST_VBODY;
          end
        end
        ST_VBODY: begin
          remain--;
          if (remain == 0) pstate = ST_AFTER;
        end
        ST_LBODY: begin
          remain--;
          if (remain == 0) pstate = ST_LITEM;
        end
        ST_LITEM: begin
          if (b == CHAR_E) begin
            pstate = ST_AFTER;
          end else if (b >= CHAR_ONE && b <= CHAR_NINE) begin
            len_acc = int'(b) - int'(CHAR_ZERO);
            pstate = ST_LLEN;
          end else begin
            close_command(STATUS_FORMAT, cnt);
          end
        end
        ST_LLEN: begin
          if (is_digit(b)) begin
            len_acc = add_digit(len_acc, b);
          end else if (b != CHAR_COLON) begin
            close_command(STATUS_FORMAT, cnt);
          end else begin
            remain = len_acc;
            pstate = ST_LBODY;
          end
        end
        default: clear_command();
      endcase
    end
  endtask

  task check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  // monitor all three channels on the rising edge
  always @(posedge clk) begin : monitor
    result_t want;
    if (rst) begin
      clear_command();
      len_limit = MAX_LEN_RESET;
      expected_commands.delete();
    end else begin
      // register write
      if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00 &&
          paddr[APB_ADDR_BITS-1:2] == REG_MAX_MESSAGE_LENGTH) begin
        len_limit = pwdata[CFG_LEN_BITS-1:0];
      end
      // result transaction
      if (m_tvalid && m_tready) begin
        if (expected_commands.size() == 0) begin
          $error("result with no command pending: status %0d, message_length %0d",
                 m_tuser, m_tdata[13:0]);
          fail_count++;
        end else begin
          want = expected_commands.pop_front();
          checked_results++;
          check_field("status", want.status, m_tuser);
          check_field("message_length", want.message_length, m_tdata[13:0]);
          check_field("cookie_length", want.cookie_length, m_tdata[27:14]);
          check_field("call_id_found", want.call_id_found, m_tdata[28]);
          check_field("call_id_offset", want.call_id_offset, m_tdata[42:29]);
          check_field("call_id_length", want.call_id_length, m_tdata[56:43]);
          check_field("tdata padding", 0, m_tdata[63:57]);
        end
      end
      // byte transaction
      if (s_tvalid && s_tready) parse_command_byte(s_tdata, s_tuser[0]);
    end
    pending_results = expected_commands.size();
  end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the bencode command framer with directed commands and random
// well-formed, broken and restarted commands under several length limits,
// with random idling on both streams and a long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  import bcf_pkg::*;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_LIMIT   = 20000;
  localparam logic [APB_ADDR_BITS-1:0] ADDR_MAX_LEN  = {REG_MAX_MESSAGE_LENGTH, 2'b00};
  localparam logic [APB_ADDR_BITS-1:0] ADDR_UNMAPPED = {~REG_MAX_MESSAGE_LENGTH, 2'b00};

  logic                     clk;
  logic                     rst;
  logic                     s_tvalid;
  logic                     s_tready;
  logic [7:0]               s_tdata;   // [7:0] data_byte
  logic [0:0]               s_tuser;   // [0] stream_restart
  logic                     m_tvalid;
  logic                     m_tready;
  logic [63:0]              m_tdata;   // [13:0] message_length, [27:14] cookie_length,
                                       // [28] call_id_found, [42:29] call_id_offset,
                                       // [56:43] call_id_length, [63:57] zero
  logic [1:0]               m_tuser;   // [1:0] status
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [APB_ADDR_BITS-1:0] paddr;
  logic [APB_DATA_BITS-1:0] pwdata;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;

  int fail_count;
  int pending_results;
  int checked_results;

  // bytes of the command being sent: {restart, byte}
  logic [8:0] cmd_bytes[$];
  int         sent_bytes;
  int         cycle_count;
  int         limit_writes;
  int         stall_left;
  bit         steady;
  bit         restart_noise;
  bit         hold_request;

  bencode_command_framer uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  command_result_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .s_tuser         (s_tuser),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .m_tuser         (m_tuser),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .pready          (pready),
    .fail_count      (fail_count),
    .pending_results (pending_results),
    .checked_results (checked_results)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $error("timeout after %0d cycles", cycle_count);
      $display("Regression FAIL");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] rand_byte();
    logic [31:0] r;
    r = $urandom;
    return r[7:0];
  endfunction

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    m_tready = 1'b0;
    stall_left = 0;
    wait (rst == 1'b0);
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        m_tready <= 1'b1;
      end else if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
        if (!steady && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  task push_byte(input logic [7:0] b);
    cmd_bytes.insert(cmd_bytes.size(), {1'b0, b});
  endtask

  task push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  // length-prefixed string with random content
  task push_string(input int n);
    push_text($sformatf("%0d", n));
    push_byte(CHAR_COLON);
    repeat (n) push_byte(rand_byte());
  endtask

  // random command, mostly well-formed, sometimes with an integer value or a zero-padded value length
  task build_command();
    int r;
    push_text("");
    repeat ($urandom_range(0, 6)) push_byte(rand_byte());
    push_text(" d");
    repeat ($urandom_range(1, 4)) begin
      r = $urandom_range(0, 9);
      if (r < 3) push_text("7:call-id");
      else if (r == 3) push_text("7:call-ix");
      else push_string($urandom_range(1, 8));
      r = $urandom_range(0, 19);
      if (r < 12) begin
        push_string($urandom_range(1, 12));
      end else if (r < 14) begin
        push_byte(CHAR_ZERO);
        push_string($urandom_range(1, 9));
      end else if (r < 19) begin
        push_byte(CHAR_L);
        repeat ($urandom_range(0, 3)) push_string($urandom_range(1, 6));
        push_byte(CHAR_E);
      end else begin
        push_text("i42e");
      end
    end
    push_byte(CHAR_E);
  endtask

  // overwrite one byte or cut the command short
  task corrupt_command();
    int p;
    int k;
    logic [8:0] junk;
    if ($urandom_range(0, 2) != 0) begin
      p = $urandom_range(0, cmd_bytes.size() - 1);
      cmd_bytes[p] = {1'b0, rand_byte()};
    end else begin
      k = $urandom_range(1, cmd_bytes.size() - 1);
      while (cmd_bytes.size() > k) junk = cmd_bytes.pop_back();
    end
  endtask

  // one byte transaction, valid held until accepted
  task send_byte(input logic [7:0] b, input bit restart);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= restart;
    do @(posedge clk); while (!s_tready);
    sent_bytes++;
  endtask

  task send_command();
    logic [8:0] item;
    bit restart;
    while (cmd_bytes.size() > 0) begin
      item = cmd_bytes.pop_front();
      restart = item[8] || (restart_noise && $urandom_range(0, 79) == 0);
      send_byte(item[7:0], restart);
    end
  endtask

  // stream idle and every result taken
  task drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task apb_write(input logic [APB_ADDR_BITS-1:0] addr, input logic [APB_DATA_BITS-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // new length limit, junk in the unused upper bits
  task set_limit(input logic [CFG_LEN_BITS-1:0] value);
    logic [APB_DATA_BITS-1:0] data;
    drain();
    data = $urandom;
    data[CFG_LEN_BITS-1:0] = value;
    apb_write(ADDR_MAX_LEN, data);
    limit_writes++;
  endtask

  task run_phase(input int target);
    int start;
    start = sent_bytes;
    while (sent_bytes - start < target) begin
      steady = ($urandom_range(0, 4) == 0);
      build_command();
      if ($urandom_range(0, 4) == 0) corrupt_command();
      send_command();
    end
    steady = 1'b0;
  endtask

  // stimulus and verdict
  initial begin : stimulus
    int waited;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    steady = 1'b0;
    restart_noise = 1'b0;
    hold_request = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed commands at the reset limit
    push_text(" d1:k1:ve");
    push_byte(8'h00);
    push_byte(8'hff);
    push_text(" d7:call-id3:");
    push_byte(8'h00);
    push_byte(8'hff);
    push_byte(8'h7f);
    push_text("e");
    push_text("ab d1:ll1:x2:yyee");
    push_text("q d7:call-idl1:ze1:k1:ve");
    push_text("c d7:call-id2:aa7:call-id3:bbbe");
    push_text(" d7:call-ix1:ae");
    push_text(" d1:ki5ee");
    push_text(" d0:");
    push_text(" dx");
    push_text(" de");
    push_text(" d1:kl0:e");
    push_text(" d1:k1:vx");
    push_text(" d1:k00:");
    push_text(" d99999x");
    push_text(" d1:k");
    cmd_bytes.insert(cmd_bytes.size(), {1'b1, CHAR_SPACE});
    push_text("d1:a1:be");
    send_command();

    // unmapped register, then the largest limit under pressure
    drain();
    apb_write(ADDR_UNMAPPED, $urandom);
    set_limit('1);
    restart_noise = 1'b1;
    hold_request = 1'b1;
    run_phase(250);

    // short limits, most commands run too long
    set_limit(CFG_LEN_BITS'($urandom_range(12, 48)));
    run_phase(250);
    set_limit(CFG_LEN_BITS'(1));
    run_phase(40);

    // medium limit with another hold-off, then back to the reset value
    set_limit(CFG_LEN_BITS'($urandom_range(49, 4000)));
    hold_request = 1'b1;
    run_phase(250);
    set_limit(MAX_LEN_RESET);
    run_phase(200);

    // wait out the last results
    s_tvalid <= 1'b0;
    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (pending_results != 0 && waited < DRAIN_LIMIT);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_results != 0) begin
      $error("%0d predicted results never arrived", pending_results);
    end

    $display("Sent %0d bytes of directed, random, broken and restarted commands", sent_bytes);
    $display("under %0d length limits; %0d results compared, %0d mismatches",
             limit_writes + 1, checked_results, fail_count);
    if (fail_count == 0 && pending_results == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/bcf_pkg.sv
hdl/bcf_cfg_regs.sv
hdl/bcf_parse_core.sv
hdl/bencode_command_framer.sv
bench/command_result_checker.sv
bench/tb_top.sv
